FILE: hdl/assert_macros.svh
// Assertion macros shared by the address generator RTL.
// Simulation builds get the checks; builds with SYNTH defined get empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Clocked check, muted while reset is high.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Clocked check that also holds during reset.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ASSERT_CLK(lbl, prop, msg)
`define ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

FILE: hdl/abag_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and tables for the compressed-texture address generator.
// No dependencies; used by every module under hdl.
package abag_pkg;

  localparam int TABLE_DEPTH_DEF = 4096;

  localparam int X_W      = 14;
  localparam int IDX_W    = 28;  // (16383 * 8191) + 16383 fits in 28 bits
  localparam int ADDR_W   = 24;
  localparam int BYTES_W  = 8;
  localparam int CFG_W    = 13;
  localparam int CFG_IDX_W = 3;
  localparam int RECIP_W  = 19;
  localparam int RECIP_SH = 18;  // exact quotient for 14-bit dividends, divisors up to 15

  localparam logic [BYTES_W-1:0] BLOCK_BYTES = 8'd16;
  localparam logic [BYTES_W-1:0] META_BYTES  = 8'd3;

  localparam logic [1:0] MODE_PLAIN  = 2'd0;
  localparam logic [1:0] MODE_GRID4  = 2'd1;
  localparam logic [1:0] MODE_GRID12 = 2'd2;

  localparam logic [3:0] GRID_SMALL = 4'd4;
  localparam logic [3:0] GRID_LARGE = 4'd12;

  localparam logic [CFG_IDX_W-1:0] REG_MODE           = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_WIDTH    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_HEIGHT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCKS_PER_ROW = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TABLE_ENTRIES  = 3'd4;

  localparam int OUT_DEPTH = 4;
  localparam int OUT_PTR_W = 2;
  localparam int OUT_LVL_W = 3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_IDX,
    ST_LOOK,
    ST_DATA
  } state_t;

  typedef struct packed {
    logic [ADDR_W-1:0]  addr;
    logic [BYTES_W-1:0] bytes;
    logic               meta;
    logic               err;
    logic               last;
  } res_t;

  typedef struct packed {
    logic [OUT_LVL_W-1:0] level;
    logic                 room2;  // space for a full two-request access
  } fifo_stat_t;

  // ceil(2^18 / d); a divisor of zero counts as one
  function automatic logic [RECIP_W-1:0] recip(input logic [3:0] d);
    logic [RECIP_W-1:0] r;
    case (d)
      4'd0:    r = 19'd262144;
      4'd1:    r = 19'd262144;
      4'd2:    r = 19'd131072;
      4'd3:    r = 19'd87382;
      4'd4:    r = 19'd65536;
      4'd5:    r = 19'd52429;
      4'd6:    r = 19'd43691;
      4'd7:    r = 19'd37450;
      4'd8:    r = 19'd32768;
      4'd9:    r = 19'd29128;
      4'd10:   r = 19'd26215;
      4'd11:   r = 19'd23832;
      4'd12:   r = 19'd21846;
      4'd13:   r = 19'd20165;
      4'd14:   r = 19'd18725;
      4'd15:   r = 19'd17477;
      default: r = 19'd262144;
    endcase
    return r;
  endfunction

  // 16-byte blocks in a 12x12 grid cell for each block type
  function automatic logic [3:0] type_blocks(input logic [2:0] t);
    logic [3:0] n;
    case (t) inside
      3'd0:          n = 4'd9;
      3'd1:          n = 4'd4;
      [3'd2 : 3'd5]: n = 4'd6;
      default:       n = 4'd1;
    endcase
    return n;
  endfunction

endpackage

FILE: hdl/abag_div.sv
`timescale 1ns / 1ps
// Divide a 14-bit coordinate by a 4-bit block size through a reciprocal multiply.
// Depends on abag_pkg (reciprocal table and widths).
module abag_div (
  input  logic                      clk,
  input  logic                      en,
  input  logic [abag_pkg::X_W-1:0]  num,
  input  logic [3:0]                den,
  output logic [abag_pkg::X_W-1:0]  quo
);

  localparam int PROD_W = abag_pkg::X_W + abag_pkg::RECIP_W;

  logic [PROD_W-1:0] prod;

  assign prod = PROD_W'(num) * PROD_W'(abag_pkg::recip(den));

  always_ff @(posedge clk) begin
    if (en) begin
      quo <= prod[abag_pkg::RECIP_SH +: abag_pkg::X_W];
    end
  end

endmodule

FILE: hdl/abag_out_fifo.sv
`timescale 1ns / 1ps
// Four-entry result queue between the lookup sequencer and the output stream.
// Depends on abag_pkg (res_t, fifo_stat_t).
module abag_out_fifo (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  abag_pkg::res_t        push_res,
  output logic                  out_valid,
  input  logic                  out_ready,
  output abag_pkg::res_t        out_res,
  output abag_pkg::fifo_stat_t  stat
);

  abag_pkg::res_t                   slots [abag_pkg::OUT_DEPTH];
  logic [abag_pkg::OUT_PTR_W-1:0]   wr_ptr;
  logic [abag_pkg::OUT_PTR_W-1:0]   rd_ptr;
  logic [abag_pkg::OUT_LVL_W-1:0]   level;
  logic                             pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (level != '0);
  assign out_res   = slots[rd_ptr];

  assign stat.level = level;
  assign stat.room2 = (level <= abag_pkg::OUT_LVL_W'(abag_pkg::OUT_DEPTH - 2));

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   level <= level + 1'b1;
        2'b01:   level <= level - 1'b1;
        default: level <= level;
      endcase
    end
  end

endmodule

FILE: hdl/astc_block_address_generator.sv
`timescale 1ns / 1ps
// Top level of the compressed-texture block address generator: config, sequencer,
// metadata table memory. Depends on abag_pkg, abag_div, abag_out_fifo.
//
//  channel  | direction | fields
//  ---------+-----------+------------------------------------------------------------
//  s_*      | in        | tuser: kind; tdata: x, y, entry index, offset, type
//  m_*      | out       | tdata: address, bytes; tuser: metadata, error; tlast: last
//  cfg_*    | in        | write enable, register index, 13-bit data
//
// A load item is written to the table memory at acceptance. A texel access runs through
// coordinate divide (reciprocal multiply), index multiply-add, then table read with the
// first request, where it ends in plain mode or on an index error; in an adaptive mode
// the payload request from the registered read data follows.
// A new item is taken once the sequencer is idle and the result queue has two free
// slots; stalls on the output only fill the queue. Reset clears control state and
// configuration; the table holds no valid bits and reads of unwritten slots are junk.
`include "assert_macros.svh"

module astc_block_address_generator #(
  parameter int TABLE_DEPTH = abag_pkg::TABLE_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [63:0]                     s_tdata,   // x[13:0] y[27:14] entry_index[39:28]
                                                     // entry_offset[55:40] entry_type[58:56]
  input  logic                            s_tuser,   // kind
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [31:0]                     m_tdata,   // request_address[23:0] request_bytes[31:24]
  output logic [1:0]                      m_tuser,   // is_metadata_fetch[0] index_error[1]
  output logic                            m_tlast,
  input  logic                            cfg_we,
  input  logic [abag_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [abag_pkg::CFG_W-1:0]      cfg_data
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int IDX_W = abag_pkg::IDX_W;
  localparam int ADDR_W = abag_pkg::ADDR_W;

  // configuration
  logic [1:0]                  mode;
  logic [3:0]                  block_width;
  logic [3:0]                  block_height;
  logic [12:0]                 blocks_per_row;
  logic [12:0]                 table_entries;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= abag_pkg::MODE_PLAIN;
      block_width    <= 4'd4;
      block_height   <= 4'd4;
      blocks_per_row <= 13'd1;
      table_entries  <= 13'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        abag_pkg::REG_MODE:           mode           <= cfg_data[1:0];
        abag_pkg::REG_BLOCK_WIDTH:    block_width    <= cfg_data[3:0];
        abag_pkg::REG_BLOCK_HEIGHT:   block_height   <= cfg_data[3:0];
        abag_pkg::REG_BLOCKS_PER_ROW: blocks_per_row <= cfg_data;
        abag_pkg::REG_TABLE_ENTRIES:  table_entries  <= cfg_data;
        default: ;
      endcase
    end
  end

  // input fields
  logic [13:0] in_x;
  logic [13:0] in_y;
  logic [11:0] in_entry;
  logic [15:0] in_offset;
  logic [2:0]  in_type;

  assign in_x      = s_tdata[13:0];
  assign in_y      = s_tdata[27:14];
  assign in_entry  = s_tdata[39:28];
  assign in_offset = s_tdata[55:40];
  assign in_type   = s_tdata[58:56];

  logic accept;
  logic load_we;
  logic access_go;

  assign accept    = s_tvalid && s_tready;
  assign load_we   = accept && !s_tuser && (32'(in_entry) < 32'(TABLE_DEPTH));
  assign access_go = accept && s_tuser;

  logic adaptive;
  logic [3:0] den_x;
  logic [3:0] den_y;

  assign adaptive = (mode == abag_pkg::MODE_GRID4) || (mode == abag_pkg::MODE_GRID12);
  assign den_x = !adaptive ? block_width :
                 (mode == abag_pkg::MODE_GRID4) ? abag_pkg::GRID_SMALL : abag_pkg::GRID_LARGE;
  assign den_y = !adaptive ? block_height :
                 (mode == abag_pkg::MODE_GRID4) ? abag_pkg::GRID_SMALL : abag_pkg::GRID_LARGE;

  // sequencer state
  abag_pkg::state_t state;
  abag_pkg::state_t state_next;

  logic [13:0]       x_q;
  logic [13:0]       y_q;
  logic [13:0]       qx;
  logic [13:0]       qy;
  logic [IDX_W-1:0]  idx_q;
  logic              in_range;

  always_ff @(posedge clk) begin
    if (access_go) begin
      x_q <= in_x;
      y_q <= in_y;
    end
  end

  abag_div u_div_x (
    .clk (clk),
    .en  (state == abag_pkg::ST_DIV),
    .num (x_q),
    .den (den_x),
    .quo (qx)
  );

  abag_div u_div_y (
    .clk (clk),
    .en  (state == abag_pkg::ST_DIV),
    .num (y_q),
    .den (den_y),
    .quo (qy)
  );

  always_ff @(posedge clk) begin
    if (state == abag_pkg::ST_IDX) begin
      idx_q <= IDX_W'(qy) * IDX_W'(blocks_per_row) + IDX_W'(qx);
    end
  end

  assign in_range = (idx_q < IDX_W'(table_entries)) && (idx_q < IDX_W'(TABLE_DEPTH));

  // metadata table: {offset, type} per slot
  logic [18:0]          table_mem [TABLE_DEPTH];
  logic [18:0]          rd_q;
  logic [IDX_W-1:0]     wr_wide;
  logic [AW-1:0]        wr_addr;
  logic [AW-1:0]        rd_addr;

  assign wr_wide = IDX_W'(in_entry);
  assign wr_addr = wr_wide[AW-1:0];
  assign rd_addr = idx_q[AW-1:0];

  // writes only happen while idle, so a read never overlaps a write of its slot
  always_ff @(posedge clk) begin
    if (load_we) begin
      table_mem[wr_addr] <= {in_offset, in_type};
    end
  end

  always_ff @(posedge clk) begin
    if (state == abag_pkg::ST_LOOK) begin
      rd_q <= table_mem[rd_addr];
    end
  end

  // result queue
  abag_pkg::fifo_stat_t fifo_stat;
  abag_pkg::res_t       push_res;
  abag_pkg::res_t       out_res;
  logic                 push;

  abag_out_fifo u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_res  (push_res),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_res   (out_res),
    .stat      (fifo_stat)
  );

  assign m_tdata = {out_res.bytes, out_res.addr};
  assign m_tuser = {out_res.err, out_res.meta};
  assign m_tlast = out_res.last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= abag_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      abag_pkg::ST_IDLE: begin
        if (access_go) begin
          state_next = abag_pkg::ST_DIV;
        end
      end
      abag_pkg::ST_DIV:  state_next = abag_pkg::ST_IDX;
      abag_pkg::ST_IDX:  state_next = abag_pkg::ST_LOOK;
      abag_pkg::ST_LOOK: begin
        state_next = (adaptive && in_range) ? abag_pkg::ST_DATA : abag_pkg::ST_IDLE;
      end
      abag_pkg::ST_DATA: state_next = abag_pkg::ST_IDLE;
      default:           state_next = abag_pkg::ST_IDLE;
    endcase
  end

  logic [ADDR_W-1:0] plain_addr;
  logic [ADDR_W-1:0] meta_addr;
  logic [ADDR_W-1:0] data_addr;
  logic [15:0]       rd_offset;
  logic [2:0]        rd_type;

  assign rd_offset  = rd_q[18:3];
  assign rd_type    = rd_q[2:0];
  assign plain_addr = {idx_q[ADDR_W-5:0], 4'b0000};
  assign meta_addr  = {idx_q[ADDR_W-2:0], 1'b0} + idx_q[ADDR_W-1:0];
  assign data_addr  = ADDR_W'({table_entries, 1'b0}) + ADDR_W'(table_entries)
                    + ADDR_W'({rd_offset, 4'b0000});

  always_comb begin
    s_tready = 1'b0;
    push     = 1'b0;
    push_res = '0;
    case (state)
      abag_pkg::ST_IDLE: s_tready = fifo_stat.room2;
      abag_pkg::ST_LOOK: begin
        push = 1'b1;
        if (!adaptive) begin
          push_res.addr  = plain_addr;
          push_res.bytes = abag_pkg::BLOCK_BYTES;
          push_res.last  = 1'b1;
        end else if (!in_range) begin
          push_res.err  = 1'b1;
          push_res.last = 1'b1;
        end else begin
          push_res.addr  = meta_addr;
          push_res.bytes = abag_pkg::META_BYTES;
          push_res.meta  = 1'b1;
        end
      end
      abag_pkg::ST_DATA: begin
        push           = 1'b1;
        push_res.addr  = data_addr;
        push_res.bytes = (mode == abag_pkg::MODE_GRID4) ? abag_pkg::BLOCK_BYTES
                         : {abag_pkg::type_blocks(rd_type), 4'b0000};
        push_res.last  = 1'b1;
      end
      default: ;
    endcase
  end

  logic push_meta;
  logic push_err;
  logic at_look;
  logic at_data;

  assign push_meta = push && push_res.meta;
  assign push_err  = push && push_res.err;
  assign at_look   = (state == abag_pkg::ST_LOOK);
  assign at_data   = (state == abag_pkg::ST_DATA);

  `ASSERT_CLK(a_push_room, push |-> (fifo_stat.level < 3'(abag_pkg::OUT_DEPTH)), "overflow")
  `ASSERT_CLK(a_data_order, at_data |-> $past(at_look && push_meta), "payload out of order")
  `ASSERT_CLK(a_meta_not_last, push_meta |-> !push_res.last, "metadata request marked last")
  `ASSERT_CLK(a_err_alone, push_err |-> (push_res.last && !push_res.meta && adaptive), "bad error")
  `ASSERT_ALWAYS(a_no_load_busy, load_we |-> (state == abag_pkg::ST_IDLE), "write while busy")

endmodule

FILE: tb/sv/astc_block_address_generator_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for astc_block_address_generator: sends table loads and texel
// accesses, predicts every memory request and compares it on the request stream.
// Depends on abag_pkg and the RTL under hdl.
module astc_block_address_generator_tb;

  localparam int         TBL_DEPTH     = abag_pkg::TABLE_DEPTH_DEF;
  localparam logic       KIND_LOAD     = 1'b0;
  localparam logic       KIND_ACCESS   = 1'b1;
  localparam logic [1:0] MODE_UNUSED   = 2'd3;
  localparam int         SETTLE_CYCLES = 12;
  localparam int         STALL_LIMIT   = 400;
  localparam int         PHASE_ITEMS   = 135;
  localparam int         TAIL_ITEMS    = 120;

  logic                           clk;
  logic                           rst;
  logic                           s_tvalid;
  logic                           s_tready;
  logic [63:0]                    s_tdata;   // x[13:0] y[27:14] entry_index[39:28]
                                             // entry_offset[55:40] entry_type[58:56]
  logic                           s_tuser;   // kind
  logic                           m_tvalid;
  logic                           m_tready;
  logic [31:0]                    m_tdata;   // request_address[23:0] request_bytes[31:24]
  logic [1:0]                     m_tuser;   // is_metadata_fetch[0] index_error[1]
  logic                           m_tlast;
  logic                           cfg_we;
  logic [abag_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [abag_pkg::CFG_W-1:0]     cfg_data;

  // register copies as last written
  logic [1:0]                 cur_mode;
  logic [3:0]                 cur_bw;
  logic [3:0]                 cur_bh;
  logic [abag_pkg::CFG_W-1:0] cur_bpr;
  logic [abag_pkg::CFG_W-1:0] cur_entries;

  logic [15:0] offset_mem  [TBL_DEPTH];
  logic [2:0]  type_mem    [TBL_DEPTH];
  bit          slot_loaded [TBL_DEPTH];

  abag_pkg::res_t predicted_requests [$];
  abag_pkg::res_t head_request;

  int mismatches;
  int n_loads;
  int n_accesses;
  int n_settings;
  int n_requests;
  int idle_cycles;
  bit quiet_mode;

  astc_block_address_generator u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    $display("[%0t] %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
  endtask

  task automatic check_field(input string what, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  task automatic queue_request(input abag_pkg::res_t req);
    predicted_requests.insert(predicted_requests.size(), req);
  endtask

  function automatic bit is_adaptive();
    return cur_mode == abag_pkg::MODE_GRID4 || cur_mode == abag_pkg::MODE_GRID12;
  endfunction

  function automatic logic [3:0] grid_size();
    return (cur_mode == abag_pkg::MODE_GRID12) ? abag_pkg::GRID_LARGE : abag_pkg::GRID_SMALL;
  endfunction

  function automatic logic [7:0] payload_blocks(input logic [2:0] t);
    case (t) inside
      3'd0:          return 8'd9;
      3'd1:          return 8'd4;
      [3'd2 : 3'd5]: return 8'd6;
      default:       return 8'd1;
    endcase
  endfunction

  function automatic logic [63:0] block_index(input logic [13:0] x, input logic [13:0] y);
    logic [63:0] bw;
    logic [63:0] bh;
    if (is_adaptive()) begin
      bw = 64'(grid_size());
      bh = bw;
    end else begin
      // a zero block size counts as one texel
      bw = (cur_bw == 0) ? 64'd1 : 64'(cur_bw);
      bh = (cur_bh == 0) ? 64'd1 : 64'(cur_bh);
    end
    return (y / bh) * cur_bpr + x / bw;
  endfunction

  function automatic logic [63:0] pack_item(input logic [13:0] x, input logic [13:0] y,
                                            input logic [11:0] slot, input logic [15:0] off,
                                            input logic [2:0] typ);
    return {5'b0, typ, off, slot, y, x};
  endfunction

  task automatic predict_requests(input logic kind, input logic [63:0] item);
    logic [13:0]    x;
    logic [13:0]    y;
    logic [11:0]    slot;
    logic [63:0]    idx;
    logic [63:0]    addr;
    abag_pkg::res_t req;
    x    = item[13:0];
    y    = item[27:14];
    slot = item[39:28];
    if (kind == KIND_LOAD) begin
      offset_mem[slot]  = item[55:40];
      type_mem[slot]    = item[58:56];
      slot_loaded[slot] = 1'b1;
    end else begin
      idx      = block_index(x, y);
      req      = '0;
      req.last = 1'b1;
      if (!is_adaptive()) begin
        addr      = idx * abag_pkg::BLOCK_BYTES;
        req.addr  = addr[abag_pkg::ADDR_W-1:0];
        req.bytes = abag_pkg::BLOCK_BYTES;
        queue_request(req);
      end else if (idx >= cur_entries || idx >= TBL_DEPTH) begin
        // no lookup: one flagged request with empty address and length
        req.err = 1'b1;
        queue_request(req);
      end else begin
        addr      = idx * abag_pkg::META_BYTES;
        req.addr  = addr[abag_pkg::ADDR_W-1:0];
        req.bytes = abag_pkg::META_BYTES;
        req.meta  = 1'b1;
        req.last  = 1'b0;
        queue_request(req);
        addr      = abag_pkg::META_BYTES * cur_entries
                  + offset_mem[idx[11:0]] * abag_pkg::BLOCK_BYTES;
        req.addr  = addr[abag_pkg::ADDR_W-1:0];
        req.bytes = (cur_mode == abag_pkg::MODE_GRID4) ? abag_pkg::BLOCK_BYTES :
                    abag_pkg::BLOCK_BYTES * payload_blocks(type_mem[idx[11:0]]);
        req.meta  = 1'b0;
        req.last  = 1'b1;
        queue_request(req);
      end
    end
  endtask

  task automatic send_item(input logic kind, input logic [63:0] item);
    if (!quiet_mode && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= item;
    do @(posedge clk); while (s_tready !== 1'b1);
    predict_requests(kind, item);
    if (kind == KIND_LOAD) n_loads++;
    else n_accesses++;
  endtask

  task automatic send_load(input logic [11:0] slot, input logic [15:0] off,
                           input logic [2:0] typ);
    send_item(KIND_LOAD, pack_item(14'($urandom), 14'($urandom), slot, off, typ));
  endtask

  task automatic send_access(input logic [13:0] x, input logic [13:0] y);
    logic [63:0] idx;
    idx = block_index(x, y);
    // a lookup may only hit a loaded slot: load it first
    if (is_adaptive() && idx < cur_entries && idx < TBL_DEPTH && !slot_loaded[idx[11:0]])
      send_load(idx[11:0], 16'($urandom), 3'($urandom));
    send_item(KIND_ACCESS, pack_item(x, y, 12'($urandom), 16'($urandom), 3'($urandom)));
  endtask

  // texel access that lands in grid cell s; falls back to a random texel if out of range
  task automatic access_slot(input logic [12:0] s);
    logic [63:0] col;
    logic [63:0] row;
    logic [63:0] g;
    logic [63:0] x;
    logic [63:0] y;
    g   = 64'(grid_size());
    col = (cur_bpr == 0) ? 64'(s) : s % cur_bpr;
    row = (cur_bpr == 0) ? 64'd0 : s / cur_bpr;
    x   = col * g + 64'($urandom_range(0, 32'(g - 1)));
    y   = row * g + 64'($urandom_range(0, 32'(g - 1)));
    if (x > 16383 || y > 16383) begin
      x = 64'($urandom_range(0, 16383));
      y = 64'($urandom_range(0, 16383));
    end
    send_access(x[13:0], y[13:0]);
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (predicted_requests.size() != 0) @(posedge clk);
    // loads give no request: let the last one retire too
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [abag_pkg::CFG_IDX_W-1:0] idx,
                           input logic [abag_pkg::CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      abag_pkg::REG_MODE:           cur_mode    = val[1:0];
      abag_pkg::REG_BLOCK_WIDTH:    cur_bw      = val[3:0];
      abag_pkg::REG_BLOCK_HEIGHT:   cur_bh      = val[3:0];
      abag_pkg::REG_BLOCKS_PER_ROW: cur_bpr     = val;
      abag_pkg::REG_TABLE_ENTRIES:  cur_entries = val;
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [1:0] mode, input logic [3:0] bw, input logic [3:0] bh,
                            input logic [abag_pkg::CFG_W-1:0] bpr,
                            input logic [abag_pkg::CFG_W-1:0] entries);
    wait_idle();
    write_reg(abag_pkg::REG_MODE, abag_pkg::CFG_W'(mode));
    write_reg(abag_pkg::REG_BLOCK_WIDTH, abag_pkg::CFG_W'(bw));
    write_reg(abag_pkg::REG_BLOCK_HEIGHT, abag_pkg::CFG_W'(bh));
    write_reg(abag_pkg::REG_BLOCKS_PER_ROW, bpr);
    write_reg(abag_pkg::REG_TABLE_ENTRIES, entries);
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  task automatic run_random_item();
    int pick;
    pick = $urandom_range(0, 99);
    // now and then hold the sender until the block has drained
    if ($urandom_range(0, 149) == 0) wait_idle();
    if (pick >= 85)
      send_load(12'($urandom), 16'($urandom), 3'($urandom));
    else if (is_adaptive() && pick < 70 && cur_entries != 0)
      access_slot(13'($urandom_range(0, cur_entries - 1)));
    else if (pick < 10)
      send_access(14'($urandom_range(0, 255)), 14'($urandom_range(0, 255)));
    else
      send_access(14'($urandom), 14'($urandom));
  endtask

  task automatic test_directed_plain();
    set_config(abag_pkg::MODE_PLAIN, 4'd4, 4'd4, 13'd1, 13'd0);
    send_access(14'd0, 14'd0);
    send_access(14'h3FFF, 14'h3FFF);
    send_load(12'hFFF, 16'hFFFF, 3'd7);
    // the unused mode code behaves as plain
    set_config(MODE_UNUSED, 4'd12, 4'd12, 13'd4096, 13'd0);
    send_access(14'($urandom), 14'($urandom));
    // zero block size, address past 24 bits wraps
    set_config(abag_pkg::MODE_PLAIN, 4'd0, 4'd0, 13'd8191, 13'd0);
    send_access(14'h3FFF, 14'h3FFF);
    send_access(14'd5, 14'd7);
    set_config(abag_pkg::MODE_PLAIN, 4'd15, 4'd15, 13'd8191, 13'd8191);
    send_access(14'h3FFF, 14'd0);
  endtask

  task automatic test_directed_adaptive();
    set_config(abag_pkg::MODE_GRID12, 4'd4, 4'd4, 13'd8, 13'd8);
    // every block type, the unused code 7 included
    for (int t = 0; t < 8; t++) begin
      send_load(12'(t), (t == 0) ? 16'hFFFF : 16'($urandom), 3'(t));
      access_slot(13'(t));
    end
    access_slot(13'd8);
    set_config(abag_pkg::MODE_GRID4, 4'd4, 4'd4, 13'd8, 13'd8);
    access_slot(13'd0);
    access_slot(13'd7);
    send_access(14'h3FFF, 14'h3FFF);
  endtask

  task automatic test_random_phases();
    for (int p = 0; p < 10; p++) begin
      case (p)
        0: set_config(abag_pkg::MODE_PLAIN, 4'($urandom), 4'($urandom), 13'($urandom),
                      13'($urandom));
        1: set_config(abag_pkg::MODE_GRID4, 4'($urandom), 4'($urandom), 13'd64, 13'd4096);
        2: set_config(abag_pkg::MODE_GRID12, 4'd4, 4'd4, 13'd16, 13'd300);
        3: set_config(abag_pkg::MODE_GRID12, 4'd12, 4'd12, 13'd1, 13'd4096);
        4: set_config(MODE_UNUSED, 4'd12, 4'd4, 13'd4096, 13'd0);
        5: set_config(abag_pkg::MODE_GRID4, 4'd0, 4'd0, 13'd8191, 13'd8191);
        6: set_config(abag_pkg::MODE_GRID12, 4'd4, 4'd4, 13'($urandom_range(1, 64)), 13'd0);
        7: set_config(abag_pkg::MODE_PLAIN, 4'd4, 4'd12, 13'd1, 13'd1);
        8: set_config(abag_pkg::MODE_GRID4, 4'd4, 4'd4, 13'($urandom_range(1, 100)),
                      13'($urandom_range(1, 4096)));
        default: set_config(abag_pkg::MODE_GRID12, 4'd4, 4'd4, 13'($urandom_range(1, 200)),
                            13'($urandom_range(1, 8191)));
      endcase
      for (int i = 0; i < PHASE_ITEMS; i++) run_random_item();
    end
  endtask

  task automatic test_tail_no_idle();
    quiet_mode = 1'b1;
    set_config(abag_pkg::MODE_GRID12, 4'd4, 4'd4, 13'd32, 13'd1024);
    for (int i = 0; i < TAIL_ITEMS; i++) run_random_item();
  endtask

  initial begin
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!quiet_mode && $urandom_range(0, 5) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (predicted_requests.size() == 0) begin
        report_mismatch("request with none pending", m_tdata, 32'd0);
      end else begin
        head_request = predicted_requests.pop_front();
        check_field("request address", m_tdata[23:0], head_request.addr);
        check_field("request bytes", m_tdata[31:24], head_request.bytes);
        check_field("metadata flag", m_tuser[0], head_request.meta);
        check_field("index error", m_tuser[1], head_request.err);
        check_field("last", m_tlast, head_request.last);
        n_requests++;
      end
    end
  end

  // end the run when nothing moves on any port for too long
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", idle_cycles);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    rst         <= 1'b1;
    s_tvalid    <= 1'b0;
    s_tdata     <= '0;
    s_tuser     <= KIND_LOAD;
    cfg_we      <= 1'b0;
    cfg_index   <= abag_pkg::REG_MODE;
    cfg_data    <= '0;
    cur_mode     = abag_pkg::MODE_PLAIN;
    cur_bw       = 4'd4;
    cur_bh       = 4'd4;
    cur_bpr      = 13'd1;
    cur_entries  = 13'd0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    test_directed_plain();
    test_directed_adaptive();
    test_random_phases();
    test_tail_no_idle();
    wait_idle();

    if (predicted_requests.size() != 0)
      report_mismatch("requests never issued", predicted_requests.size(), 32'd0);
    $display("Run: %0d items (%0d table loads, %0d texel accesses) over %0d register settings",
             n_loads + n_accesses, n_loads, n_accesses, n_settings);
    $display("Run: %0d requests compared, %0d field errors", n_requests, mismatches);
    if (mismatches == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+hdl
hdl/abag_pkg.sv
hdl/abag_div.sv
hdl/abag_out_fifo.sv
hdl/astc_block_address_generator.sv
tb/sv/astc_block_address_generator_tb.sv
